// ===== design/ouq_pkg.sv =====
// Shared types and constants for the ultrasonic occupancy qualifier.
package ouq_pkg;

  localparam int CHANNELS        = 4;
  localparam int MAX_SAMPLES_DEF = 16;
  localparam int ECHO_W          = 15;
  localparam int VOTE_W          = 5;
  localparam int THR_W           = 9;
  localparam int DWELL_W         = 16;
  localparam int TIME_W          = 32;
  localparam int UNST_W          = 3;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 16;
  // Scaled distance domain: echo_us * 17, compared against cm * 1000.
  localparam int SCL_W           = 20;

  localparam logic [ECHO_W-1:0] ECHO_TIMEOUT_US = ECHO_W'(20000);
  localparam logic [SCL_W-1:0]  CM_NUM          = SCL_W'(17);
  localparam logic [SCL_W-1:0]  CM_DEN          = SCL_W'(1000);

  localparam logic [THR_W-1:0]   ENTER_RST = THR_W'(10);
  localparam logic [THR_W-1:0]   EXIT_RST  = THR_W'(14);
  localparam logic [VOTE_W-1:0]  CONF_RST  = VOTE_W'(3);
  localparam logic [DWELL_W-1:0] DWELL_RST = DWELL_W'(500);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENTER = 2'd0,
    REG_EXIT  = 2'd1,
    REG_CONF  = 2'd2,
    REG_DWELL = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [SCL_W-1:0]   enter_lim;  // enter threshold times 1000
    logic [SCL_W-1:0]   exit_lim;   // (exit threshold + 1) times 1000
    logic [VOTE_W-1:0]  conf;
    logic [DWELL_W-1:0] dwell;
  } cfg_t;

  typedef struct packed {
    logic              filt;
    logic [VOTE_W-1:0] votes;
    logic              unstable;
  } lane_res_t;

endpackage

// ===== design/ouq_lane.sv =====
// One channel lane: sample vote, vote counter and dwell-qualified filtered state.
module ouq_lane #(
  parameter int MAX_SAMPLES = ouq_pkg::MAX_SAMPLES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      acc,
  input  logic                      last,
  input  logic [ouq_pkg::ECHO_W-1:0] echo,
  input  logic [ouq_pkg::TIME_W-1:0] now,
  input  ouq_pkg::cfg_t             cfg,
  output ouq_pkg::lane_res_t        res
);
  import ouq_pkg::*;

  localparam logic [VOTE_W-1:0] MAX_V = VOTE_W'(MAX_SAMPLES);

  logic              filt_r, filt_nxt;
  logic [TIME_W-1:0] chg_r, chg_nxt;
  logic [VOTE_W-1:0] cnt_r, cnt_nxt;

  logic [SCL_W-1:0]  scaled;
  logic              echo_ok;
  logic              vote;
  logic [VOTE_W-1:0] v;
  logic              raw;
  logic [TIME_W-1:0] elapsed;
  logic              change;

  // Thresholds are compared in the scaled domain, so no division is needed.
  assign scaled  = SCL_W'(echo) * CM_NUM;
  assign echo_ok = (echo != '0) && (echo <= ECHO_TIMEOUT_US) && (scaled >= CM_DEN);

  always_comb begin
    if (filt_r) begin
      vote = echo_ok && (scaled < cfg.exit_lim);
    end else begin
      vote = echo_ok && (scaled < cfg.enter_lim);
    end
    v       = (vote && (cnt_r < MAX_V)) ? cnt_r + VOTE_W'(1) : cnt_r;
    raw     = (v >= cfg.conf);
    elapsed = now - chg_r;
    change  = (raw != filt_r) && (elapsed >= TIME_W'(cfg.dwell));

    filt_nxt = filt_r;
    chg_nxt  = chg_r;
    cnt_nxt  = cnt_r;
    if (acc) begin
      if (last) begin
        cnt_nxt = '0;
        if (change) begin
          filt_nxt = raw;
          chg_nxt  = now;
        end
      end else begin
        cnt_nxt = v;
      end
    end

    res.filt     = change ? raw : filt_r;
    res.votes    = v;
    res.unstable = (v == cfg.conf) ||
                   (({1'b0, v} + (VOTE_W+1)'(1)) == {1'b0, cfg.conf});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_r <= 1'b0;
      chg_r  <= '0;
      cnt_r  <= '0;
    end else begin
      filt_r <= filt_nxt;
      chg_r  <= chg_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

// ===== design/ouq_merge.sv =====
// Merge stage: gathers lane decisions into the mask, vote list and unstable count.
module ouq_merge (
  input  ouq_pkg::lane_res_t [ouq_pkg::CHANNELS-1:0]                      lanes,
  output logic [ouq_pkg::CHANNELS-1:0]                                    mask,
  output logic [ouq_pkg::CHANNELS-1:0][ouq_pkg::VOTE_W-1:0]               votes,
  output logic [ouq_pkg::UNST_W-1:0]                                      unstable
);
  import ouq_pkg::*;

  always_comb begin
    unstable = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      mask[c]  = lanes[c].filt;
      votes[c] = lanes[c].votes;
      unstable = unstable + UNST_W'(lanes[c].unstable);
    end
  end

endmodule

// ===== design/ultrasonic_occupancy_qualifier.sv =====
// Top level of the ultrasonic occupancy qualifier.
// Each input item carries one echo time per channel, a last_of_cycle mark and
// the current time in ms. Four lanes vote on their channel in parallel and a
// merge stage combines them. Items without the mark only count votes and give
// no result; a marked item closes the sensor cycle and gives one result item
// with the filtered mask, the vote counts and the unstable count.
// Throughput: one input item per clock while in_stall is low. The result of a
// marked item is registered in the output register, or in the skid entry if that is held.
// The result side has an output register and one skid entry. in_stall rises
// only while the skid entry holds a waiting result, so a stalled receiver
// holds back the input after two pending results; nothing is dropped.
// Configuration is written through cfg_we/cfg_index/cfg_wdata while idle;
// thresholds are stored pre-scaled by 1000 at write time.
// Reset (rst_n low at a clock edge) restores register defaults, clears all
// vote counters, filtered states and change times, and empties the output.
module ultrasonic_occupancy_qualifier #(
  parameter int MAX_SAMPLES = ouq_pkg::MAX_SAMPLES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ouq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ouq_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ouq_pkg::ECHO_W-1:0]     in_echo_time_0,
  input  logic [ouq_pkg::ECHO_W-1:0]     in_echo_time_1,
  input  logic [ouq_pkg::ECHO_W-1:0]     in_echo_time_2,
  input  logic [ouq_pkg::ECHO_W-1:0]     in_echo_time_3,
  input  logic                          in_last_of_cycle,
  input  logic [ouq_pkg::TIME_W-1:0]     in_now_ms,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ouq_pkg::CHANNELS-1:0]   out_occupied_mask,
  output logic [ouq_pkg::VOTE_W-1:0]     out_votes_0,
  output logic [ouq_pkg::VOTE_W-1:0]     out_votes_1,
  output logic [ouq_pkg::VOTE_W-1:0]     out_votes_2,
  output logic [ouq_pkg::VOTE_W-1:0]     out_votes_3,
  output logic [ouq_pkg::UNST_W-1:0]     out_unstable_count
);
  import ouq_pkg::*;

  typedef struct packed {
    logic [CHANNELS-1:0]             mask;
    logic [CHANNELS-1:0][VOTE_W-1:0] votes;
    logic [UNST_W-1:0]               unstable;
  } res_t;

  cfg_t cfg_r, cfg_nxt;

  logic                            acc;
  logic [CHANNELS-1:0][ECHO_W-1:0] echo;
  lane_res_t [CHANNELS-1:0]        lanes;
  res_t                            res_new;

  logic out_valid_r, out_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  res_t out_r, out_nxt;
  res_t skid_r, skid_nxt;
  logic out_take;
  logic new_res;

  // Configuration registers, thresholds kept in the scaled distance domain.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_ENTER: cfg_nxt.enter_lim = SCL_W'(cfg_wdata[THR_W-1:0]) * CM_DEN;
        REG_EXIT:  cfg_nxt.exit_lim  = (SCL_W'(cfg_wdata[THR_W-1:0]) + SCL_W'(1)) * CM_DEN;
        REG_CONF:  cfg_nxt.conf      = cfg_wdata[VOTE_W-1:0];
        REG_DWELL: cfg_nxt.dwell     = cfg_wdata[DWELL_W-1:0];
        default:   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enter_lim <= SCL_W'(ENTER_RST) * CM_DEN;
      cfg_r.exit_lim  <= (SCL_W'(EXIT_RST) + SCL_W'(1)) * CM_DEN;
      cfg_r.conf      <= CONF_RST;
      cfg_r.dwell     <= DWELL_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_stall = skid_valid_r;
  assign acc      = in_valid && !in_stall;

  assign echo[0] = in_echo_time_0;
  assign echo[1] = in_echo_time_1;
  assign echo[2] = in_echo_time_2;
  assign echo[3] = in_echo_time_3;

  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    ouq_lane #(
      .MAX_SAMPLES(MAX_SAMPLES)
    ) u_lane (
      .clk  (clk),
      .rst_n(rst_n),
      .acc  (acc),
      .last (in_last_of_cycle),
      .echo (echo[c]),
      .now  (in_now_ms),
      .cfg  (cfg_r),
      .res  (lanes[c])
    );
  end

  ouq_merge u_merge (
    .lanes   (lanes),
    .mask    (res_new.mask),
    .votes   (res_new.votes),
    .unstable(res_new.unstable)
  );

  // Output register plus one skid entry; the skid drains first.
  always_comb begin
    out_take       = out_valid_r && !out_stall;
    new_res        = acc && in_last_of_cycle;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      if (out_take) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (new_res) begin
      if (!out_valid_r || out_take) begin
        out_nxt       = res_new;
        out_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = res_new;
        skid_valid_nxt = 1'b1;
      end
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_occupied_mask  = out_r.mask;
  assign out_votes_0        = out_r.votes[0];
  assign out_votes_1        = out_r.votes[1];
  assign out_votes_2        = out_r.votes[2];
  assign out_votes_3        = out_r.votes[3];
  assign out_unstable_count = out_r.unstable;

  // A waiting skid entry always sits behind a full output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid while output register empty");

  // Vote counts never exceed the saturation limit.
  a_votes_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.votes[0] <= VOTE_W'(MAX_SAMPLES)) &&
                    (out_r.votes[1] <= VOTE_W'(MAX_SAMPLES)) &&
                    (out_r.votes[2] <= VOTE_W'(MAX_SAMPLES)) &&
                    (out_r.votes[3] <= VOTE_W'(MAX_SAMPLES)))
    else $error("vote count above saturation limit");

  // A marked item accepted with room ahead shows up as a result next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_last_of_cycle && !out_valid_r) |=> out_valid_r)
    else $error("result of a marked item did not appear");

endmodule
